FILE: hdl/fpfa_pkg.sv
// Package for the fixed-partition fit allocator: field widths, item and status codes,
// the fit unit's control struct and the built-in partition sizes.
// No dependencies.
`default_nettype none
package fpfa_pkg;

    localparam int SIZE_W             = 12;
    localparam int EIDX_W             = 4;
    localparam int PIDX_W             = 4;
    localparam int FUNC_W             = 2;
    localparam int STAT_W             = 2;
    localparam int DEF_NUM_PARTITIONS = 12;
    localparam int DEFAULT_COUNT      = 12;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_RESTORE = 2'd1,
        FUNC_WRITE   = 2'd2
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_GRANT   = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_UPDATED = 2'd2
    } t_status;

    typedef struct packed {
        logic clear;
        logic eval;
        logic mode;
    } t_fit_ctl;

    localparam logic [SIZE_W-1:0] DEFAULT_SIZES [DEFAULT_COUNT] = '{
        12'd160, 12'd350, 12'd650, 12'd80,  12'd410, 12'd50,
        12'd720, 12'd905, 12'd570, 12'd130, 12'd260, 12'd830
    };

    function automatic logic [SIZE_W-1:0] default_size(input int unsigned idx);
        logic [SIZE_W-1:0] v;
        v = '0;
        if (idx < DEFAULT_COUNT) begin
            v = DEFAULT_SIZES[idx];
        end
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/fpfa_table.sv
// Partition size table: one write port, one registered read port, per-entry valid bits.
// An entry that is not valid reads as its built-in size. Depends on fpfa_pkg.
`default_nettype none
module fpfa_table
    import fpfa_pkg::*;
#(
    parameter int NUM_PARTITIONS = DEF_NUM_PARTITIONS,
    localparam int IDX_W = $clog2(NUM_PARTITIONS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_clr,
    input  wire logic              i_we,
    input  wire logic [IDX_W-1:0]  i_waddr,
    input  wire logic [SIZE_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [IDX_W-1:0]  i_raddr,
    output logic                   o_rd_vld,
    output logic [IDX_W-1:0]       o_rd_addr,
    output logic [SIZE_W-1:0]      o_rd_data
);

    logic [SIZE_W-1:0]         r_mem [NUM_PARTITIONS];
    logic [NUM_PARTITIONS-1:0] r_valid;
    logic [SIZE_W-1:0]         r_rd_data;
    logic                      r_rd_vbit;
    logic [IDX_W-1:0]          r_rd_addr;
    logic                      r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_raddr];
            r_rd_vbit <= r_valid[i_raddr];
            r_rd_addr <= i_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_re;
            if (i_clr) begin
                r_valid <= '0;
            end else if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_rd_vld  = r_rd_vld;
    assign o_rd_addr = r_rd_addr;
    assign o_rd_data = r_rd_vbit ? r_rd_data : default_size(32'(r_rd_addr));

endmodule
`default_nettype wire

FILE: hdl/fpfa_fit_unit.sv
// Shared compare/subtract unit: checks one table entry per cycle against the request
// and keeps the current pick. Depends on fpfa_pkg.
`default_nettype none
module fpfa_fit_unit
    import fpfa_pkg::*;
#(
    parameter int NUM_PARTITIONS = DEF_NUM_PARTITIONS,
    localparam int IDX_W = $clog2(NUM_PARTITIONS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_fit_ctl          i_ctl,
    input  wire logic [SIZE_W-1:0] i_req,
    input  wire logic [SIZE_W-1:0] i_size,
    input  wire logic [IDX_W-1:0]  i_addr,
    output logic                   o_found,
    output logic [IDX_W-1:0]       o_pick,
    output logic [SIZE_W-1:0]      o_size
);

    logic              r_found;
    logic [IDX_W-1:0]  r_pick;
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] r_left;
    logic              fits;
    logic [SIZE_W-1:0] left;
    logic              upd;

    always_comb begin
        fits = (i_size != '0) && (i_size >= i_req);
        left = i_size - i_req;
        upd  = i_ctl.eval && fits && (!r_found || (i_ctl.mode && (left < r_left)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (upd) begin
            r_found <= 1'b1;
        end
        if (upd) begin
            r_pick <= i_addr;
            r_size <= i_size;
            r_left <= left;
        end
    end

    assign o_found = r_found;
    assign o_pick  = r_pick;
    assign o_size  = r_size;

endmodule
`default_nettype wire

FILE: hdl/fixed_partition_fit_allocator_core.sv
// Top level of the fixed-partition fit allocator: sequencer, APB register, output register.
// Instantiates fpfa_table and fpfa_fit_unit; depends on fpfa_pkg.
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+------------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | tuser func, tdata req/index/size
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | tuser status, tdata index/size
//  apb       | in        | psel, penable, pready = 1     | fit_mode at byte address 0
//
// An allocate item scans every table entry before its result is loaded: the scan reads
// one table entry per cycle through the single read port into the shared fit unit.
// Restore, write and unused items skip the scan. Reset restores the built-in sizes at
// once through per-entry valid bits. A result waiting in the output register does not
// block the next transfer; the sequencer holds before loading while it is still occupied.
`default_nettype none
module fixed_partition_fit_allocator_core
    import fpfa_pkg::*;
#(
    parameter int NUM_PARTITIONS = DEF_NUM_PARTITIONS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // req_size[11:0], entry_index[15:12],
                                             // entry_size[27:16], zero[31:28]
    input  wire logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // part_index[3:0], part_size[15:4]
    output logic [1:0]       m_axis_tuser,   // status[1:0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IDX_W = $clog2(NUM_PARTITIONS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_addr, n_addr;
    t_func              r_func;
    logic [SIZE_W-1:0]  r_req;
    logic               r_fit_mode, n_fit_mode;
    logic               r_o_valid, n_o_valid;
    logic [STAT_W-1:0]  r_o_status;
    logic [PIDX_W-1:0]  r_o_index;
    logic [SIZE_W-1:0]  r_o_size;

    logic               accept;
    logic               load;
    t_func              in_func;
    logic [SIZE_W-1:0]  in_req;
    logic [EIDX_W-1:0]  in_eidx;
    logic [SIZE_W-1:0]  in_esize;
    logic               tbl_clr;
    logic               tbl_we;
    logic [IDX_W-1:0]   tbl_waddr;
    logic [SIZE_W-1:0]  tbl_wdata;
    logic               tbl_re;
    logic               rd_vld;
    logic [IDX_W-1:0]   rd_addr;
    logic [SIZE_W-1:0]  rd_data;
    t_fit_ctl           fit_ctl;
    logic               fit_found;
    logic [IDX_W-1:0]   fit_pick;
    logic [SIZE_W-1:0]  fit_size;
    t_status            done_status;

    assign in_func  = t_func'(s_axis_tuser);
    assign in_req   = s_axis_tdata[11:0];
    assign in_eidx  = s_axis_tdata[15:12];
    assign in_esize = s_axis_tdata[27:16];

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign load          = (r_state == S_DONE) && (!r_o_valid || m_axis_tready);

    always_comb begin
        case (r_func)
            FUNC_ALLOC:   done_status = fit_found ? ST_GRANT : ST_NOFIT;
            FUNC_RESTORE: done_status = ST_UPDATED;
            FUNC_WRITE:   done_status = ST_UPDATED;
            default:      done_status = ST_NOFIT;
        endcase
    end

    always_comb begin
        tbl_clr   = accept && (in_func == FUNC_RESTORE);
        tbl_we    = 1'b0;
        tbl_waddr = IDX_W'(in_eidx);
        tbl_wdata = in_esize;
        if (accept && (in_func == FUNC_WRITE) && (int'(in_eidx) < NUM_PARTITIONS)) begin
            tbl_we = 1'b1;
        end else if (load && (r_func == FUNC_ALLOC) && fit_found) begin
            tbl_we    = 1'b1;
            tbl_waddr = fit_pick;
            tbl_wdata = '0;
        end
        tbl_re       = (r_state == S_SCAN);
        fit_ctl.clear = accept;
        fit_ctl.eval  = rd_vld;
        fit_ctl.mode  = r_fit_mode;
    end

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_fit_mode = r_fit_mode;
        n_o_valid  = r_o_valid && !m_axis_tready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_addr  = '0;
                    n_state = (in_func == FUNC_ALLOC) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                n_addr = IDX_W'(r_addr + 1'b1);
                if (r_addr == IDX_W'(NUM_PARTITIONS - 1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load) begin
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (psel && penable && pwrite && pready && !paddr[2]) begin
            n_fit_mode = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_addr     <= '0;
            r_fit_mode <= 1'b1;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_fit_mode <= n_fit_mode;
            r_o_valid  <= n_o_valid;
        end
        if (accept) begin
            r_func <= in_func;
            r_req  <= in_req;
        end
        if (load) begin
            r_o_status <= done_status;
            if (done_status == ST_GRANT) begin
                r_o_index <= PIDX_W'(fit_pick);
                r_o_size  <= fit_size;
            end else begin
                r_o_index <= '0;
                r_o_size  <= '0;
            end
        end
    end

    fpfa_table #(
        .NUM_PARTITIONS (NUM_PARTITIONS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (tbl_clr),
        .i_we      (tbl_we),
        .i_waddr   (tbl_waddr),
        .i_wdata   (tbl_wdata),
        .i_re      (tbl_re),
        .i_raddr   (r_addr),
        .o_rd_vld  (rd_vld),
        .o_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    fpfa_fit_unit #(
        .NUM_PARTITIONS (NUM_PARTITIONS)
    ) u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fit_ctl),
        .i_req   (r_req),
        .i_size  (rd_data),
        .i_addr  (rd_addr),
        .o_found (fit_found),
        .o_pick  (fit_pick),
        .o_size  (fit_size)
    );

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_size, r_o_index};
    assign m_axis_tuser  = r_o_status;
    assign pready        = 1'b1;
    assign prdata        = paddr[2] ? 32'd0 : {31'd0, r_fit_mode};

endmodule
`default_nettype wire
